// ----- rtl/crkbc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the chained rotating-key byte cipher.
// No dependencies.
package crkbc_pkg;

  localparam int unsigned BYTE_W = 8;

  localparam logic [BYTE_W-1:0] CHAIN_IV = 8'hCB;

  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    byte_t rolling_key;
    byte_t chain;
  } cipher_state_t;

  // k mod 3 == 0, using 4 == 1 (mod 3): weight even bits by 1, odd bits by 2
  function automatic logic key_is_mult3(input byte_t k);
    logic [3:0] acc;
    acc = 4'(k[0]) + 4'(k[2]) + 4'(k[4]) + 4'(k[6])
        + {3'(k[1]) + 3'(k[3]) + 3'(k[5]) + 3'(k[7]), 1'b0};
    case (acc) inside
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12: key_is_mult3 = 1'b1;
      default:                       key_is_mult3 = 1'b0;
    endcase
  endfunction

  function automatic byte_t advance_key(input byte_t k);
    if (key_is_mult3(k)) begin
      advance_key = {k[4:0], k[7:5]};
    end else begin
      advance_key = {k[5:0], k[7:6]};
    end
  endfunction

endpackage

// ----- rtl/crkbc_core.sv -----
`timescale 1ns / 1ps
// Combinational datapath: key advance, chain-driven bit mix and next-state selection.
// Depends on crkbc_pkg.
module crkbc_core (
  input  logic                    mode,
  input  crkbc_pkg::byte_t        data_in,
  input  logic                    first_of_message,
  input  crkbc_pkg::byte_t        cipher_key,
  input  crkbc_pkg::cipher_state_t state_cur,
  output crkbc_pkg::byte_t        data_out,
  output crkbc_pkg::cipher_state_t state_nxt
);

  crkbc_pkg::byte_t key_base;
  crkbc_pkg::byte_t chain_base;
  crkbc_pkg::byte_t key_adv;
  crkbc_pkg::byte_t work;
  crkbc_pkg::byte_t mixed;

  assign key_base   = first_of_message ? cipher_key : state_cur.rolling_key;
  assign chain_base = first_of_message ? crkbc_pkg::CHAIN_IV : state_cur.chain;
  assign key_adv    = crkbc_pkg::advance_key(key_base);

  always_comb begin
    work  = chain_base;
    mixed = '0;
    for (int i = 0; i < crkbc_pkg::BYTE_W; i++) begin
      if (key_adv[i]) begin
        work = {work[0], work[crkbc_pkg::BYTE_W-1:1]};
      end
      mixed[i] = data_in[i] ^ work[crkbc_pkg::BYTE_W-1-i];
    end
  end

  assign data_out              = mixed;
  assign state_nxt.rolling_key = key_adv;
  assign state_nxt.chain       = (mode == crkbc_pkg::MODE_DECRYPT) ? data_in : mixed;

endmodule

// ----- rtl/chained_rotating_key_byte_cipher.sv -----
`timescale 1ns / 1ps
// Top level of the chained rotating-key byte cipher: handshake, state and output registers.
// Depends on crkbc_pkg and crkbc_core.
//
// One byte in, one byte out, one transfer per cycle sustained while the output is not
// stalled. An accepted byte waits in the input register until the output register can
// take it, is mixed against the rolling key and chain state in a single combinational
// pass and lands in the output register, which sets out_valid. The rolling key and
// chain advance as each byte moves into the output register, which lets the next
// byte follow immediately. cfg_wr_data is captured whenever cfg_wr_en is high and
// is used on the next byte with first_of_message set.
module chained_rotating_key_byte_cipher (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [7:0]             cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_mode,
  input  logic [7:0]             in_data_in,
  input  logic                   in_first_of_message,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_data_out
);

  crkbc_pkg::byte_t          cipher_key_r;
  crkbc_pkg::cipher_state_t  state_r;
  crkbc_pkg::cipher_state_t  state_nxt;
  logic                      s1_valid_r;
  logic                      s1_mode_r;
  crkbc_pkg::byte_t          s1_data_r;
  logic                      s1_first_r;
  logic                      out_valid_r;
  crkbc_pkg::byte_t          out_data_r;
  crkbc_pkg::byte_t          mix_data;
  logic                      s1_advance;
  logic                      in_xfer;

  assign s1_advance = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready   = !s1_valid_r || s1_advance;
  assign in_xfer    = in_valid && in_ready;

  crkbc_core u_core (
    .mode             (s1_mode_r),
    .data_in          (s1_data_r),
    .first_of_message (s1_first_r),
    .cipher_key       (cipher_key_r),
    .state_cur        (state_r),
    .data_out         (mix_data),
    .state_nxt        (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cipher_key_r      <= '0;
      state_r.rolling_key <= '0;
      state_r.chain     <= crkbc_pkg::CHAIN_IV;
      s1_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cipher_key_r <= cfg_wr_data;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_advance) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_mode_r  <= in_mode;
      s1_data_r  <= in_data_in;
      s1_first_r <= in_first_of_message;
    end
    if (s1_advance) begin
      out_data_r <= mix_data;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;

endmodule

// ----- rtl/crkbc_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the chained rotating-key byte cipher, bound to the top level.
// Depends on chained_rotating_key_byte_cipher.
module crkbc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_data_out
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_out))
    else $error("stalled result changed or dropped");

  // drop results on reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // out_valid follows every input transfer, behind the input register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> ##1 out_valid)
    else $error("result missing after input transfer");

  // backpressure only from a stalled output
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output free");

endmodule

bind chained_rotating_key_byte_cipher crkbc_checker u_crkbc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_data_out (out_data_out)
);
